// ===== rtl/core/sg9_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the 9-point Savitzky-Golay smoother.
// Used by the tap cells, the divider stages, the result emitter and the top level.

package sg9_pkg;

  // Record length register.
  localparam int              LEN_BITS  = 16;
  localparam logic [15:0]     LEN_RESET = 16'd1024;

  // Kernel: (-21, 14, 39, 54, 59, 54, 39, 14, -21) / 231.
  localparam int NUM_TAPS  = 9;
  localparam int COEF_BITS = 8;
  localparam logic signed [COEF_BITS-1:0] KERNEL_COEF [NUM_TAPS] = '{
    -8'sd21, 8'sd14, 8'sd39, 8'sd54, 8'sd59, 8'sd54, 8'sd39, 8'sd14, -8'sd21
  };

  // Division by the kernel norm, one radix-256 digit per stage.
  localparam int                   DIGIT_BITS = 8;
  localparam logic [DIGIT_BITS:0]  DIVISOR    = 9'd231;

  // Results trail the input by LAG positions; EDGE positions at the start of a
  // record and EDGE-1 at its end are copied.
  localparam int LAG       = 4;
  localparam int EDGE      = 9;
  localparam int KEEP_TAPS = LAG + 1;

  // Up to five results per request.
  localparam int MAX_RESULTS = 5;
  localparam int CNT_BITS    = 3;
  localparam int FIDX_BITS   = 2;

  typedef struct packed {
    logic                has_main;
    logic                smooth;
    logic                fin;
    logic [CNT_BITS-1:0] nflush;
  } sg9_ctrl_t;

endpackage

// ===== rtl/core/sg9_tap_cell.sv =====
`timescale 1ns / 1ps
// One cell of the transposed kernel chain: adds coefficient times sample to
// the partial sum from its neighbor. Uses sg9_pkg for the coefficient width.

module sg9_tap_cell #(
  parameter int SAMPLE_BITS = 24,
  parameter int ACC_BITS    = 33
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic signed [sg9_pkg::COEF_BITS-1:0] coef,
  input  logic signed [ACC_BITS-1:0]           psum_in,
  output logic signed [ACC_BITS-1:0]           psum
);

  localparam int PROD_BITS = SAMPLE_BITS + sg9_pkg::COEF_BITS;

  logic signed [PROD_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]  psum_next;

  assign prod      = PROD_BITS'(sample) * PROD_BITS'(coef);
  assign psum_next = psum_in + ACC_BITS'(prod);

  always_ff @(posedge clk) begin
    if (en) begin
      psum <= psum_next;
    end
  end

endmodule

// ===== rtl/core/sg9_div_stage.sv =====
`timescale 1ns / 1ps
// One stage of the restoring divider by the kernel norm: eight quotient bits.
// Uses sg9_pkg for the digit width and divisor.

module sg9_div_stage #(
  parameter int DIV_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [sg9_pkg::DIGIT_BITS+DIV_BITS-1:0] work_in,
  output logic [sg9_pkg::DIGIT_BITS+DIV_BITS-1:0] work
);

  // The upper digit holds the running remainder; the lower part shifts the
  // dividend out at the top while quotient bits shift in at the bottom.
  logic [sg9_pkg::DIGIT_BITS-1:0]                rem;
  logic [DIV_BITS-1:0]                           acc;
  logic [sg9_pkg::DIGIT_BITS:0]                  trial;
  logic [sg9_pkg::DIGIT_BITS+DIV_BITS-1:0]       work_next;

  always_comb begin
    rem = work_in[DIV_BITS +: sg9_pkg::DIGIT_BITS];
    acc = work_in[DIV_BITS-1:0];
    for (int b = 0; b < sg9_pkg::DIGIT_BITS; b++) begin
      trial = {rem, acc[DIV_BITS-1]};
      acc   = {acc[DIV_BITS-2:0], 1'b0};
      if (trial >= sg9_pkg::DIVISOR) begin
        rem    = sg9_pkg::DIGIT_BITS'(trial - sg9_pkg::DIVISOR);
        acc[0] = 1'b1;
      end else begin
        rem = trial[sg9_pkg::DIGIT_BITS-1:0];
      end
    end
    work_next = {rem, acc};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work <= work_next;
    end
  end

endmodule

// ===== rtl/core/sg9_emit.sv =====
`timescale 1ns / 1ps
// Result emitter: unpacks one request's results into a short shift queue and
// hands them out one per cycle unless stalled; uses sg9_pkg's control struct.

module sg9_emit #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          load_valid,
  input  sg9_pkg::sg9_ctrl_t                            ctrl,
  input  logic [SAMPLE_BITS-1:0]                        main_value,
  input  logic [sg9_pkg::LAG-1:0][SAMPLE_BITS-1:0]      flush_taps,
  output logic                                          ready,
  output logic                                          result_valid,
  input  logic                                          result_stall,
  output logic signed [SAMPLE_BITS-1:0]                 smoothed,
  output logic                                          last_of_run,
  output logic                                          record_end
);

  localparam int N = sg9_pkg::MAX_RESULTS;
  localparam int CB = sg9_pkg::CNT_BITS;

  logic [CB-1:0]          cnt;
  logic [CB-1:0]          total;
  logic [CB-1:0]          pos;
  logic [sg9_pkg::FIDX_BITS-1:0] fidx;
  logic                   load;
  logic                   take;

  logic [SAMPLE_BITS-1:0] slot_val [N];
  logic                   slot_last [N];
  logic                   slot_end [N];
  logic [SAMPLE_BITS-1:0] val_next [N];
  logic                   last_next [N];
  logic                   end_next [N];

  assign ready        = (cnt == '0) || ((cnt == CB'(1)) && !result_stall);
  assign load         = load_valid && ready;
  assign result_valid = (cnt != '0);
  assign take         = result_valid && !result_stall;
  assign total        = CB'(ctrl.has_main) + ctrl.nflush;

  // The main position comes first, then the flushed positions oldest first.
  always_comb begin
    pos  = '0;
    fidx = '0;
    for (int i = 0; i < N; i++) begin
      pos  = CB'(i) - CB'(ctrl.has_main);
      fidx = sg9_pkg::FIDX_BITS'(ctrl.nflush - CB'(1) - pos);
      if (ctrl.has_main && (i == 0)) begin
        val_next[i] = main_value;
      end else begin
        val_next[i] = flush_taps[fidx];
      end
      last_next[i] = (CB'(i) == (total - CB'(1)));
      end_next[i]  = last_next[i] && ctrl.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= total;
    end else if (take) begin
      cnt <= cnt - CB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < N; i++) begin
        slot_val[i]  <= val_next[i];
        slot_last[i] <= last_next[i];
        slot_end[i]  <= end_next[i];
      end
    end else if (take) begin
      for (int i = 0; i < N - 1; i++) begin
        slot_val[i]  <= slot_val[i+1];
        slot_last[i] <= slot_last[i+1];
        slot_end[i]  <= slot_end[i+1];
      end
    end
  end

  assign smoothed    = slot_val[0];
  assign last_of_run = slot_last[0];
  assign record_end  = slot_end[0];

endmodule

// ===== rtl/core/savitzky_golay_9pt_smoother.sv =====
`timescale 1ns / 1ps
// Top level of the streaming 9-point quadratic Savitzky-Golay smoother.
// Depends on sg9_pkg, sg9_tap_cell, sg9_div_stage and sg9_emit.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+--------------------------------------
//   sample    | sample_valid, sample_stall | sample
//   result    | result_valid, result_stall | smoothed, last_of_run, record_end
//   config    | cfg_wen                    | cfg_wdata (record_length)
//
// One request is taken per cycle unless sample_stall is high. The nine-cell
// kernel chain updates at each request; the sum then passes an absolute-value
// stage, (SAMPLE_BITS+15)/8 divider stages and a saturation stage before the
// emitter. The final sample of a record yields up to five results, one per
// cycle while result_stall is low, and sample_stall may be raised while the
// emitter drains them. A stall on the result side freezes the whole pipe only
// while the saturation stage holds a request that the emitter cannot take.
// Reset is synchronous and clears the record index, the pipe valids and the
// emitter; record_length returns to 1024.

module savitzky_golay_9pt_smoother #(
  parameter int SAMPLE_BITS = 24,
  parameter int INDEX_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [sg9_pkg::LEN_BITS-1:0]        cfg_wdata,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [SAMPLE_BITS-1:0]       smoothed,
  output logic                                last_of_run,
  output logic                                record_end
);

  localparam int ACC_BITS   = SAMPLE_BITS + 9;
  localparam int MAG_BITS   = SAMPLE_BITS + 8;
  localparam int DIV_STAGES = (MAG_BITS + sg9_pkg::DIGIT_BITS - 1) / sg9_pkg::DIGIT_BITS;
  localparam int DIV_BITS   = DIV_STAGES * sg9_pkg::DIGIT_BITS;
  localparam int WORK_BITS  = sg9_pkg::DIGIT_BITS + DIV_BITS;
  localparam int CMP_BITS   = ((INDEX_BITS > sg9_pkg::LEN_BITS) ?
                               INDEX_BITS : sg9_pkg::LEN_BITS) + 1;
  localparam int LAST       = DIV_STAGES + 1;
  localparam int KT         = sg9_pkg::KEEP_TAPS;
  localparam int CB         = sg9_pkg::CNT_BITS;

  localparam logic [DIV_BITS-1:0] POS_LIMIT =
    (DIV_BITS'(1) << (SAMPLE_BITS - 1)) - DIV_BITS'(1);
  localparam logic [DIV_BITS-1:0] NEG_LIMIT = DIV_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] MAX_SAMPLE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] MIN_SAMPLE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration and record position.
  logic [sg9_pkg::LEN_BITS-1:0] record_length;
  logic [INDEX_BITS-1:0]        sample_index;
  logic [INDEX_BITS-1:0]        sample_index_next;
  logic [CMP_BITS-1:0]          len_w;
  logic [CMP_BITS-1:0]          n_w;
  logic                         fin;
  logic                         emits;
  sg9_pkg::sg9_ctrl_t           ctrl_next;

  logic accept;
  logic adv;
  logic emit_ready;

  // Kernel chain and divider.
  wire  signed [ACC_BITS-1:0]   psum_c [sg9_pkg::NUM_TAPS+1];
  logic [ACC_BITS-1:0]          abs_val;
  logic [DIV_BITS-1:0]          mag_a;
  wire  [WORK_BITS-1:0]         work_c [DIV_STAGES+1];

  // Pipe alongside the divider.
  logic [LAST:0]                     valid_p;
  sg9_pkg::sg9_ctrl_t [LAST:0]       ctrl_p;
  logic [LAST:1]                     neg_p;
  logic signed [SAMPLE_BITS-1:0]     tap_p [LAST+1][KT];

  // Saturation stage.
  logic [DIV_BITS-1:0]                         quo;
  logic [SAMPLE_BITS-1:0]                      sat_val;
  logic [SAMPLE_BITS-1:0]                      main_next;
  logic                                        valid_f;
  sg9_pkg::sg9_ctrl_t                          ctrl_f;
  logic [SAMPLE_BITS-1:0]                      main_f;
  logic [sg9_pkg::LAG-1:0][SAMPLE_BITS-1:0]    flush_f;

  assign adv          = !valid_f || emit_ready;
  assign sample_stall = !adv;
  assign accept       = sample_valid && adv;

  // A record length of zero behaves as one.
  assign len_w = (record_length == '0) ? CMP_BITS'(1) : CMP_BITS'(record_length);
  assign n_w   = CMP_BITS'(sample_index);

  always_comb begin
    fin                = (n_w + CMP_BITS'(1)) >= len_w;
    ctrl_next.has_main = n_w >= CMP_BITS'(sg9_pkg::LAG);
    ctrl_next.smooth   = (n_w >= CMP_BITS'(sg9_pkg::LAG + sg9_pkg::EDGE)) &&
                         ((n_w + CMP_BITS'(sg9_pkg::EDGE - sg9_pkg::LAG)) <= len_w);
    ctrl_next.fin      = fin;
    if (!fin) begin
      ctrl_next.nflush = '0;
    end else if (n_w >= CMP_BITS'(sg9_pkg::LAG - 1)) begin
      ctrl_next.nflush = CB'(sg9_pkg::LAG);
    end else begin
      ctrl_next.nflush = CB'(n_w) + CB'(1);
    end
    emits             = ctrl_next.has_main || fin;
    sample_index_next = fin ? '0 : sample_index + INDEX_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_length <= sg9_pkg::LEN_RESET;
      sample_index  <= '0;
    end else begin
      if (cfg_wen) begin
        record_length <= cfg_wdata;
      end
      if (accept) begin
        sample_index <= sample_index_next;
      end
    end
  end

  // Transposed kernel: after a request, psum_c[0] holds the full weighted sum
  // centered four samples back.
  assign psum_c[sg9_pkg::NUM_TAPS] = '0;

  for (genvar k = 0; k < sg9_pkg::NUM_TAPS; k++) begin : g_cell
    sg9_tap_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_BITS    (ACC_BITS)
    ) u_cell (
      .clk     (clk),
      .en      (accept),
      .sample  (sample),
      .coef    (sg9_pkg::KERNEL_COEF[k]),
      .psum_in (psum_c[k+1]),
      .psum    (psum_c[k])
    );
  end

  assign abs_val   = psum_c[0][ACC_BITS-1] ? ACC_BITS'(-psum_c[0]) : ACC_BITS'(psum_c[0]);
  assign work_c[0] = {{sg9_pkg::DIGIT_BITS{1'b0}}, mag_a};

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    sg9_div_stage #(
      .DIV_BITS (DIV_BITS)
    ) u_div (
      .clk     (clk),
      .en      (adv),
      .work_in (work_c[j]),
      .work    (work_c[j+1])
    );
  end

  // The quotient is truncated toward zero, then clamped to the sample range.
  always_comb begin
    quo = work_c[DIV_STAGES][DIV_BITS-1:0];
    if (!neg_p[LAST]) begin
      sat_val = (quo > POS_LIMIT) ? MAX_SAMPLE : quo[SAMPLE_BITS-1:0];
    end else begin
      sat_val = (quo > NEG_LIMIT) ? MIN_SAMPLE : -quo[SAMPLE_BITS-1:0];
    end
    main_next = ctrl_p[LAST].smooth ? sat_val : tap_p[LAST][sg9_pkg::LAG];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_p <= '0;
      valid_f <= 1'b0;
    end else if (adv) begin
      valid_p <= {valid_p[LAST-1:0], accept && emits};
      valid_f <= valid_p[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl_p[0]    <= ctrl_next;
      tap_p[0][0]  <= sample;
      for (int k = 1; k < KT; k++) begin
        tap_p[0][k] <= tap_p[0][k-1];
      end
    end
    if (adv) begin
      mag_a    <= DIV_BITS'(abs_val[MAG_BITS-1:0]);
      neg_p[1] <= psum_c[0][ACC_BITS-1];
      for (int s = 2; s <= LAST; s++) begin
        neg_p[s] <= neg_p[s-1];
      end
      for (int s = 1; s <= LAST; s++) begin
        ctrl_p[s] <= ctrl_p[s-1];
        tap_p[s]  <= tap_p[s-1];
      end
      ctrl_f <= ctrl_p[LAST];
      main_f <= main_next;
      for (int k = 0; k < sg9_pkg::LAG; k++) begin
        flush_f[k] <= tap_p[LAST][k];
      end
    end
  end

  sg9_emit #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (valid_f),
    .ctrl         (ctrl_f),
    .main_value   (main_f),
    .flush_taps   (flush_f),
    .ready        (emit_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .smoothed     (smoothed),
    .last_of_run  (last_of_run),
    .record_end   (record_end)
  );

endmodule

// ===== bench/sg9_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the 9-point Savitzky-Golay smoother: watches the config, sample
// and result channels, predicts every result and compares it field by field.
// Depends on sg9_pkg for the record length width.

module sg9_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [sg9_pkg::LEN_BITS-1:0] cfg_wdata,
  input  logic                         sample_valid,
  input  logic                         sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  logic signed [SAMPLE_BITS-1:0] smoothed,
  input  logic                         last_of_run,
  input  logic                         record_end,
  output int                           mismatch_count,
  output int                           outstanding
);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    sample_t value;
    logic    last;
    logic    rec_end;
  } smoothed_word_t;

  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< (SAMPLE_BITS - 1));
  localparam logic [sg9_pkg::LEN_BITS-1:0] DEFAULT_LENGTH = 1024;
  localparam int KERNEL_NORM = 231;
  localparam int EDGE_SPAN   = 9;
  localparam int TRAIL       = 4;
  localparam int PRINT_LIMIT = 100;

  sample_t                      history [8];
  logic [15:0]                  rec_index;
  logic [sg9_pkg::LEN_BITS-1:0] rec_length;
  smoothed_word_t               smoothed_due [$];
  int                           fail_tally = 0;
  int                           due_count = 0;

  assign mismatch_count = fail_tally;
  assign outstanding    = due_count;

  task automatic report(input string msg);
    if (fail_tally < PRINT_LIMIT) $display("%0t ns: mismatch: %s", $time, msg);
    fail_tally++;
  endtask

  // One request shifts the window; it yields the position TRAIL behind it and,
  // on the final sample of a record, every position still held back.
  task automatic predict_step(input sample_t x);
    longint         v [9];
    longint         acc;
    longint         quot;
    int unsigned    n;
    int unsigned    len_eff;
    bit             fin;
    smoothed_word_t w;
    n       = rec_index;
    len_eff = (rec_length == 0) ? 1 : rec_length;
    fin     = (n + 1 >= len_eff);
    v[0]    = x;
    for (int k = 1; k < 9; k++) v[k] = history[k-1];
    for (int k = TRAIL; k >= 0; k--) begin
      if (k <= n && (k == TRAIL || fin)) begin
        if (k == TRAIL && n - TRAIL >= EDGE_SPAN && n - TRAIL + EDGE_SPAN <= len_eff) begin
          acc = 59 * v[4] + 54 * (v[3] + v[5]) + 39 * (v[2] + v[6])
              + 14 * (v[1] + v[7]) - 21 * (v[0] + v[8]);
          quot = acc / KERNEL_NORM;
          if (quot > SAT_HI) quot = SAT_HI;
          if (quot < SAT_LO) quot = SAT_LO;
          w.value = sample_t'(quot);
        end else begin
          w.value = sample_t'(v[k]);
        end
        w.last    = (k == (fin ? 0 : TRAIL));
        w.rec_end = fin && (k == 0);
        smoothed_due.push_back(w);
      end
    end
    for (int k = 7; k > 0; k--) history[k] = history[k-1];
    history[0] = x;
    rec_index  = fin ? 16'd0 : 16'(n + 1);
  endtask

  always @(posedge clk) begin : watch
    smoothed_word_t due;
    if (rst) begin
      foreach (history[k]) history[k] = '0;
      rec_index  = '0;
      rec_length = DEFAULT_LENGTH;
      smoothed_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (smoothed_due.size() == 0) begin
          report($sformatf("result %0d with nothing expected", smoothed));
        end else begin
          due = smoothed_due.pop_front();
          if (smoothed !== due.value)
            report($sformatf("smoothed %0d, expected %0d", smoothed, due.value));
          if (last_of_run !== due.last)
            report($sformatf("last_of_run %b, expected %b", last_of_run, due.last));
          if (record_end !== due.rec_end)
            report($sformatf("record_end %b, expected %b", record_end, due.rec_end));
        end
      end
      if (cfg_wen) rec_length = cfg_wdata;
      if (sample_valid && !sample_stall) predict_step(sample);
    end
    due_count = smoothed_due.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for savitzky_golay_9pt_smoother: drives records of samples
// under changing record lengths with random gaps and stalls, and gives the verdict.
// Depends on sg9_pkg, the smoother RTL and sg9_checker.

module tb;

  localparam int SAMPLE_BITS   = 24;
  localparam int LEN_BITS      = sg9_pkg::LEN_BITS;
  localparam int RANDOM_ITEMS  = 460;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 60;
  localparam int STALL_LIMIT   = 2000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef enum {WIDE, RAIL, NARROW} sample_mix_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                clk = 0;
  logic                rst = 1;
  logic                cfg_wen = 0;
  logic [LEN_BITS-1:0] cfg_wdata = '0;
  logic                sample_valid = 0;
  logic                sample_stall;
  sample_t             sample = '0;
  logic                result_valid;
  logic                result_stall = 0;
  sample_t             smoothed;
  logic                last_of_run;
  logic                record_end;
  int                  mismatch_count;
  int                  outstanding;

  bit tx_gaps = 1;
  bit rx_calm = 0;
  bit hold_results = 0;
  int random_sent = 0;

  always #2 clk = ~clk;

  savitzky_golay_9pt_smoother #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (16)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample      (sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .smoothed    (smoothed),
    .last_of_run (last_of_run),
    .record_end  (record_end)
  );

  sg9_checker #(.SAMPLE_BITS(SAMPLE_BITS)) scoreboard (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample        (sample),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .smoothed      (smoothed),
    .last_of_run   (last_of_run),
    .record_end    (record_end),
    .mismatch_count(mismatch_count),
    .outstanding   (outstanding)
  );

  task automatic write_length(input int len);
    cfg_wdata <= LEN_BITS'(len);
    cfg_wen   <= 1;
    @(negedge clk);
    cfg_wen   <= 0;
  endtask

  task automatic send_sample(input sample_t value);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      sample_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    sample       <= value;
    sample_valid <= 1;
    do @(posedge clk); while (!(sample_valid && !sample_stall));
    @(negedge clk);
  endtask

  // Items before position LAG that end no record give no result yet sit in the
  // pipe, so wait out its depth after the last result before touching the register.
  task automatic settle();
    sample_valid <= 0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic sample_t draw_sample(input sample_mix_t mix, input bit lean_high);
    case (mix)
      RAIL: begin
        if ($urandom_range(0, 3) == 0) return lean_high ? SAMPLE_MIN : SAMPLE_MAX;
        return lean_high ? SAMPLE_MAX : SAMPLE_MIN;
      end
      NARROW:  return sample_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic run_records(input int len, input int count, input sample_mix_t mix);
    bit lean_high;
    lean_high = $urandom_range(0, 1);
    tx_gaps   = ($urandom_range(0, 3) != 0);
    rx_calm   = ($urandom_range(0, 3) == 0);
    write_length(len);
    repeat (count) send_sample(draw_sample(mix, lean_high));
    random_sent += count;
    settle();
  endtask

  initial begin : receiver
    int hold;
    while (rst) @(negedge clk);
    forever begin
      if (hold_results) begin
        hold         = HOLD_CYCLES;
        hold_results = 0;
      end else begin
        hold = rx_calm ? 0 : $urandom_range(0, 4);
      end
      if (hold > 0) begin
        result_stall <= 1;
        repeat (hold) @(negedge clk);
        result_stall <= 0;
      end
      do @(posedge clk); while (!(result_valid && !result_stall));
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("savitzky_golay_9pt_smoother regression: fail");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int len;
    int count;
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Reset length, then cut the record short so one request flushes five results.
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample('1);
    send_sample(sample_t'(1));
    send_sample(sample_t'(24'h555555));
    settle();
    write_length(1);
    send_sample(SAMPLE_MIN);
    settle();

    // A zero length behaves as a one-sample record.
    write_length(0);
    send_sample(SAMPLE_MAX);
    settle();

    // Shortest record with a smoothed position; the taps drive it into saturation.
    write_length(18);
    for (int i = 0; i < 18; i++) begin
      if (i == 5 || i == 13) send_sample(SAMPLE_MIN);
      else if (i >= 6 && i <= 12) send_sample(SAMPLE_MAX);
      else send_sample(sample_t'(i * 1000 - 7000));
    end
    settle();

    run_records(65535, 30, WIDE);

    // Receiver holds off while the sender keeps offering, so the block backs up.
    write_length(40);
    tx_gaps      = 0;
    rx_calm      = 1;
    hold_results = 1;
    repeat (120) send_sample(draw_sample(WIDE, 1'b0));
    random_sent += 120;
    settle();

    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len   = $urandom_range(18, 48);
        count = len * $urandom_range(1, 3) + $urandom_range(0, 5);
      end else if (pick < 70) begin
        len   = $urandom_range(2, 17);
        count = $urandom_range(5, 30);
      end else if (pick < 80) begin
        len   = $urandom_range(0, 1);
        count = $urandom_range(3, 10);
      end else if (pick < 90) begin
        len   = pick[0] ? 65535 : 1024;
        count = $urandom_range(20, 50);
      end else begin
        len   = $urandom_range(60, 120);
        count = len;
      end
      if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
      run_records(len, count, sample_mix_t'($urandom_range(0, 2)));
    end

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("savitzky_golay_9pt_smoother regression: pass");
    end else begin
      $display("savitzky_golay_9pt_smoother regression: fail");
    end
    $finish;
  end

endmodule

// ===== savitzky_golay_9pt_smoother.f =====
rtl/core/sg9_pkg.sv
rtl/core/sg9_tap_cell.sv
rtl/core/sg9_div_stage.sv
rtl/core/sg9_emit.sv
rtl/core/savitzky_golay_9pt_smoother.sv
bench/sg9_checker.sv
bench/tb.sv
